// ===== sv/svmb_pkg.sv =====
`default_nettype none

package svmb_pkg;

  // Sizing of the voice bank and the sine table.
  localparam int VOICES         = 8;
  localparam int SINE_ADDR_BITS = 10;
  localparam int VC_W           = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int QTR_BITS       = SINE_ADDR_BITS - 2;
  localparam int QLEN           = 1 << QTR_BITS;
  localparam int SINE_IDX_W     = QTR_BITS + 1;

  // Field and datapath widths.
  localparam int PHASE_W  = 32;
  localparam int GAIN_W   = 16;
  localparam int COEF_W   = 24;
  localparam int STATE_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 25;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int TAP_W    = 3;

  localparam logic [GAIN_W-1:0] UNITY_Q15 = 16'd32768;

  // Rounding constants for the filter output and the master gain stage.
  localparam logic signed [ACC_W-1:0]  Y_HALF   = ACC_W'(1) << 19;
  localparam logic signed [PROD_W-1:0] OUT_HALF = PROD_W'(1) << 15;
  localparam int MIX_SHIFT = 14;
  localparam int Y_SHIFT   = 20;
  localparam int OUT_SHIFT = 16;

  // Register map.
  localparam int NUM_REGS  = 5;
  localparam int PADDR_W   = $clog2(4 * NUM_REGS);
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B0     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B1     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A1     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A2     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MASTER_GAIN = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 24'sd307101;
  localparam logic signed [COEF_W-1:0] COEF_B1_RESET = 24'sd614202;
  localparam logic signed [COEF_W-1:0] COEF_A1_RESET = 24'sd0;
  localparam logic signed [COEF_W-1:0] COEF_A2_RESET = 24'sd179830;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [GAIN_W-1:0]        master_gain;
  } cfg_t;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_VOICE,
    MUL_B0_X,
    MUL_B1_D1,
    MUL_B0_D2,
    MUL_A1_Y1,
    MUL_A2_Y2,
    MUL_MASTER
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V_READ,
    ST_V_LOOK,
    ST_V_MUL,
    ST_V_LAST,
    ST_X_LOAD,
    ST_TAP,
    ST_T_LAST,
    ST_Y_LOAD,
    ST_M_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            wr_voice;
    logic            tick_start;
    logic            look;
    logic            mul_en;
    mul_sel_t        mul_sel;
    logic            acc_add;
    logic            x_load;
    logic            y_load;
    logic            out_load;
    logic [VC_W-1:0] vidx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // Quarter-wave sine table, built at elaboration from an odd Taylor series.
  localparam int SINE_DIV [5] = '{110, 72, 42, 20, 6};
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] sine_tab_t [QLEN+1];

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    for (int m = 0; m <= QLEN; m++) begin
      x  = (64'(m) * HALF_PI_Q30) >> QTR_BITS;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int i = 0; i < 5; i++) begin
        t = ONE_Q30 - (((x2 * t) >> 30) / 64'(SINE_DIV[i]));
      end
      s = (x * t) >> 30;
      r = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      tab[m] = r[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_QUARTER = build_sine_tab();

endpackage

`default_nettype wire

// ===== sv/svmb_ram.sv =====
`default_nettype none

// Simple dual-port RAM with one write port and a registered read port.
module svmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/svmb_regs.sv =====
`default_nettype none

// Configuration registers behind the APB-style port.
module svmb_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [svmb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output svmb_pkg::cfg_t                     cfg
);

  logic [svmb_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;
  logic [svmb_pkg::GAIN_W-1:0]    gain_in;

  assign idx     = paddr[svmb_pkg::PADDR_W-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign gain_in = (pwdata[15:0] > svmb_pkg::UNITY_Q15) ? svmb_pkg::UNITY_Q15 : pwdata[15:0];

  // Register writes; the master gain saturates at unity.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0          <= svmb_pkg::COEF_B0_RESET;
      cfg.b1          <= svmb_pkg::COEF_B1_RESET;
      cfg.a1          <= svmb_pkg::COEF_A1_RESET;
      cfg.a2          <= svmb_pkg::COEF_A2_RESET;
      cfg.master_gain <= svmb_pkg::UNITY_Q15;
    end else if (wr) begin
      case (idx)
        svmb_pkg::REG_COEF_B0:     cfg.b0 <= pwdata[svmb_pkg::COEF_W-1:0];
        svmb_pkg::REG_COEF_B1:     cfg.b1 <= pwdata[svmb_pkg::COEF_W-1:0];
        svmb_pkg::REG_COEF_A1:     cfg.a1 <= pwdata[svmb_pkg::COEF_W-1:0];
        svmb_pkg::REG_COEF_A2:     cfg.a2 <= pwdata[svmb_pkg::COEF_W-1:0];
        svmb_pkg::REG_MASTER_GAIN: cfg.master_gain <= gain_in;
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      svmb_pkg::REG_COEF_B0:     prdata = 32'({cfg.b0});
      svmb_pkg::REG_COEF_B1:     prdata = 32'({cfg.b1});
      svmb_pkg::REG_COEF_A1:     prdata = 32'({cfg.a1});
      svmb_pkg::REG_COEF_A2:     prdata = 32'({cfg.a2});
      svmb_pkg::REG_MASTER_GAIN: prdata = 32'(cfg.master_gain);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/svmb_ctrl.sv =====
`default_nettype none

// Sequencer: walks the voices, then the five filter taps, then the master gain.
module svmb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           op,
  input  wire svmb_pkg::stat_t stat,
  output svmb_pkg::cmd_t      cmd
);

  svmb_pkg::state_t               state;
  svmb_pkg::state_t               state_next;
  logic [svmb_pkg::VC_W-1:0]      vidx;
  logic [svmb_pkg::VC_W-1:0]      vidx_next;
  logic [svmb_pkg::TAP_W-1:0]     tap;
  logic [svmb_pkg::TAP_W-1:0]     tap_next;
  logic                           last_voice;
  svmb_pkg::mul_sel_t             tap_sel;

  assign last_voice = (vidx == svmb_pkg::VC_W'(svmb_pkg::VOICES - 1));

  // Filter tap order.
  always_comb begin
    case (tap)
      3'd0:    tap_sel = svmb_pkg::MUL_B0_X;
      3'd1:    tap_sel = svmb_pkg::MUL_B1_D1;
      3'd2:    tap_sel = svmb_pkg::MUL_B0_D2;
      3'd3:    tap_sel = svmb_pkg::MUL_A1_Y1;
      default: tap_sel = svmb_pkg::MUL_A2_Y2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svmb_pkg::ST_IDLE;
      vidx  <= '0;
      tap   <= '0;
    end else begin
      state <= state_next;
      vidx  <= vidx_next;
      tap   <= tap_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next     = state;
    vidx_next      = vidx;
    tap_next       = tap;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.mul_sel    = svmb_pkg::MUL_VOICE;
    cmd.vidx       = vidx;
    case (state)
      svmb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (op) begin
            cmd.tick_start = 1'b1;
            vidx_next      = '0;
            state_next     = svmb_pkg::ST_V_READ;
          end else begin
            cmd.wr_voice = 1'b1;
          end
        end
      end
      svmb_pkg::ST_V_READ: begin
        cmd.acc_add = (vidx != '0);
        state_next  = svmb_pkg::ST_V_LOOK;
      end
      svmb_pkg::ST_V_LOOK: begin
        cmd.look   = 1'b1;
        state_next = svmb_pkg::ST_V_MUL;
      end
      svmb_pkg::ST_V_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = svmb_pkg::MUL_VOICE;
        if (last_voice) begin
          state_next = svmb_pkg::ST_V_LAST;
        end else begin
          vidx_next  = vidx + 1'b1;
          state_next = svmb_pkg::ST_V_READ;
        end
      end
      svmb_pkg::ST_V_LAST: begin
        cmd.acc_add = 1'b1;
        state_next  = svmb_pkg::ST_X_LOAD;
      end
      svmb_pkg::ST_X_LOAD: begin
        cmd.x_load = 1'b1;
        tap_next   = '0;
        state_next = svmb_pkg::ST_TAP;
      end
      svmb_pkg::ST_TAP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tap_sel;
        cmd.acc_add = (tap != '0);
        if (tap == 3'd4) begin
          state_next = svmb_pkg::ST_T_LAST;
        end else begin
          tap_next = tap + 1'b1;
        end
      end
      svmb_pkg::ST_T_LAST: begin
        cmd.acc_add = 1'b1;
        state_next  = svmb_pkg::ST_Y_LOAD;
      end
      svmb_pkg::ST_Y_LOAD: begin
        cmd.y_load = 1'b1;
        state_next = svmb_pkg::ST_M_MUL;
      end
      svmb_pkg::ST_M_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = svmb_pkg::MUL_MASTER;
        state_next  = svmb_pkg::ST_OUT;
      end
      svmb_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = svmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = svmb_pkg::ST_IDLE;
      end
    endcase
  end

  // The output register is only loaded when it is empty or its word is taken in that cycle.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output register loaded while still occupied");

  // An accepted tick always starts the voice walk at voice zero.
  a_tick_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op) |=> (state == svmb_pkg::ST_V_READ) && (vidx == '0))
    else $error("tick did not start the voice walk");

endmodule

`default_nettype wire

// ===== sv/svmb_dp.sv =====
`default_nettype none

// Datapath: voice tables, sine lookup, shared multiplier, accumulator,
// biquad delay line and the output register.
module svmb_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire svmb_pkg::cmd_t                      cmd,
  output svmb_pkg::stat_t                          stat,
  input  wire svmb_pkg::cfg_t                      cfg,
  input  wire logic [2:0]                          voice,
  input  wire logic [svmb_pkg::PHASE_W-1:0]        phase_step,
  input  wire logic [svmb_pkg::GAIN_W-1:0]         voice_gain,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [svmb_pkg::SAMPLE_W-1:0]     sample
);

  localparam int SG_W = svmb_pkg::PHASE_W + svmb_pkg::GAIN_W;

  logic                                   voice_valid [svmb_pkg::VOICES];
  logic [7:0]                             voice_ext;
  logic [svmb_pkg::VC_W-1:0]              wvoice;
  logic                                   in_range;
  logic [svmb_pkg::GAIN_W-1:0]            gain_sat;
  logic                                   sg_we;
  logic [SG_W-1:0]                        sg_rdata;
  logic                                   ph_we;
  logic [svmb_pkg::VC_W-1:0]              ph_waddr;
  logic [svmb_pkg::PHASE_W-1:0]           ph_wdata;
  logic [svmb_pkg::PHASE_W-1:0]           phase;
  logic [svmb_pkg::PHASE_W-1:0]           step;
  logic [svmb_pkg::GAIN_W-1:0]            gain;
  logic                                   active;

  logic [svmb_pkg::SINE_ADDR_BITS-1:0]    sine_k;
  logic [1:0]                             quad;
  logic [svmb_pkg::QTR_BITS-1:0]          sine_r;
  logic [svmb_pkg::SINE_IDX_W-1:0]        sine_idx;
  logic [14:0]                            sine_mag;
  logic signed [15:0]                     sine_val;
  logic signed [15:0]                     sine_reg;
  logic [svmb_pkg::GAIN_W-1:0]            gain_op;

  logic signed [svmb_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [svmb_pkg::MUL_B_W-1:0]    mul_b;
  logic signed [svmb_pkg::PROD_W-1:0]     prod;
  logic signed [svmb_pkg::ACC_W-1:0]      acc;
  logic signed [svmb_pkg::MUL_B_W-1:0]    neg_a1;
  logic signed [svmb_pkg::MUL_B_W-1:0]    neg_a2;

  logic signed [svmb_pkg::STATE_W-1:0]    x_reg;
  logic signed [svmb_pkg::STATE_W-1:0]    y_reg;
  logic signed [svmb_pkg::STATE_W-1:0]    in_delay_one;
  logic signed [svmb_pkg::STATE_W-1:0]    in_delay_two;
  logic signed [svmb_pkg::STATE_W-1:0]    out_delay_one;
  logic signed [svmb_pkg::STATE_W-1:0]    out_delay_two;

  logic signed [svmb_pkg::ACC_W-1:0]      y_sum;
  logic signed [svmb_pkg::ACC_W-1:0]      y_shr;
  logic signed [svmb_pkg::STATE_W-1:0]    y_sat;
  logic signed [svmb_pkg::PROD_W-1:0]     o_sum;
  logic signed [svmb_pkg::PROD_W-1:0]     o_shr;
  logic signed [svmb_pkg::SAMPLE_W-1:0]   o_sat;

  // Voice settings write decode; gains saturate at unity.
  assign voice_ext = 8'(voice);
  assign wvoice    = voice_ext[svmb_pkg::VC_W-1:0];
  assign in_range  = (voice_ext < 8'(svmb_pkg::VOICES));
  assign gain_sat  = (voice_gain > svmb_pkg::UNITY_Q15) ? svmb_pkg::UNITY_Q15 : voice_gain;
  assign sg_we     = cmd.wr_voice && in_range;

  // One valid bit per voice stands in for the all-zero reset of the tables.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < svmb_pkg::VOICES; v++) begin
        voice_valid[v] <= 1'b0;
      end
    end else if (sg_we) begin
      voice_valid[wvoice] <= 1'b1;
    end
  end

  svmb_ram #(.WIDTH(SG_W), .DEPTH(svmb_pkg::VOICES)) u_step_gain (
    .clk   (clk),
    .we    (sg_we),
    .waddr (wvoice),
    .wdata ({phase_step, gain_sat}),
    .raddr (cmd.vidx),
    .rdata (sg_rdata)
  );

  assign step   = sg_rdata[SG_W-1:svmb_pkg::GAIN_W];
  assign gain   = sg_rdata[svmb_pkg::GAIN_W-1:0];
  assign active = voice_valid[cmd.vidx] && (step != '0) && (gain != '0);

  // Phase table: cleared on a voice's first write, advanced by active voices.
  assign ph_we    = (sg_we && !voice_valid[wvoice]) || (cmd.look && active);
  assign ph_waddr = cmd.look ? cmd.vidx : wvoice;
  assign ph_wdata = cmd.look ? (phase + step) : '0;

  svmb_ram #(.WIDTH(svmb_pkg::PHASE_W), .DEPTH(svmb_pkg::VOICES)) u_phase (
    .clk   (clk),
    .we    (ph_we),
    .waddr (ph_waddr),
    .wdata (ph_wdata),
    .raddr (cmd.vidx),
    .rdata (phase)
  );

  // Sine lookup by quarter-wave symmetry.
  assign sine_k   = phase[svmb_pkg::PHASE_W-1 -: svmb_pkg::SINE_ADDR_BITS];
  assign quad     = sine_k[svmb_pkg::SINE_ADDR_BITS-1 -: 2];
  assign sine_r   = sine_k[svmb_pkg::QTR_BITS-1:0];
  assign sine_idx = quad[0] ? (svmb_pkg::SINE_IDX_W'(svmb_pkg::QLEN) - {1'b0, sine_r})
                            : {1'b0, sine_r};
  assign sine_mag = svmb_pkg::SINE_QUARTER[sine_idx];
  assign sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

  // Silent voices feed zeros, since the phase of a never-written voice is unknown.
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      sine_reg <= active ? sine_val : '0;
      gain_op  <= active ? gain : '0;
    end
  end

  // Operand select for the shared multiplier.
  assign neg_a1 = -svmb_pkg::MUL_B_W'(cfg.a1);
  assign neg_a2 = -svmb_pkg::MUL_B_W'(cfg.a2);

  always_comb begin
    case (cmd.mul_sel)
      svmb_pkg::MUL_VOICE: begin
        mul_a = svmb_pkg::MUL_A_W'(sine_reg);
        mul_b = $signed({9'b0, gain_op});
      end
      svmb_pkg::MUL_B0_X: begin
        mul_a = x_reg;
        mul_b = svmb_pkg::MUL_B_W'(cfg.b0);
      end
      svmb_pkg::MUL_B1_D1: begin
        mul_a = in_delay_one;
        mul_b = svmb_pkg::MUL_B_W'(cfg.b1);
      end
      svmb_pkg::MUL_B0_D2: begin
        mul_a = in_delay_two;
        mul_b = svmb_pkg::MUL_B_W'(cfg.b0);
      end
      svmb_pkg::MUL_A1_Y1: begin
        mul_a = out_delay_one;
        mul_b = neg_a1;
      end
      svmb_pkg::MUL_A2_Y2: begin
        mul_a = out_delay_two;
        mul_b = neg_a2;
      end
      svmb_pkg::MUL_MASTER: begin
        mul_a = y_reg;
        mul_b = $signed({9'b0, cfg.master_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Accumulator: voice mix first, then the filter sum.
  always_ff @(posedge clk) begin
    if (cmd.tick_start || cmd.x_load) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + svmb_pkg::ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.x_load) begin
      x_reg <= svmb_pkg::STATE_W'(acc >>> svmb_pkg::MIX_SHIFT);
    end
  end

  // Filter output: round half up to Q16.16 and saturate to 32 bits.
  assign y_sum = acc + svmb_pkg::Y_HALF;
  assign y_shr = y_sum >>> svmb_pkg::Y_SHIFT;

  always_comb begin
    if ((&y_shr[svmb_pkg::ACC_W-1:svmb_pkg::STATE_W-1]) ||
        !(|y_shr[svmb_pkg::ACC_W-1:svmb_pkg::STATE_W-1])) begin
      y_sat = y_shr[svmb_pkg::STATE_W-1:0];
    end else if (y_shr[svmb_pkg::ACC_W-1]) begin
      y_sat = {1'b1, {(svmb_pkg::STATE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(svmb_pkg::STATE_W-1){1'b1}}};
    end
  end

  // Delay line update.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_delay_one  <= '0;
      in_delay_two  <= '0;
      out_delay_one <= '0;
      out_delay_two <= '0;
    end else if (cmd.y_load) begin
      in_delay_two  <= in_delay_one;
      in_delay_one  <= x_reg;
      out_delay_two <= out_delay_one;
      out_delay_one <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.y_load) begin
      y_reg <= y_sat;
    end
  end

  // Master gain result: round half up to Q1.15 and saturate.
  assign o_sum = prod + svmb_pkg::OUT_HALF;
  assign o_shr = o_sum >>> svmb_pkg::OUT_SHIFT;

  always_comb begin
    if ((&o_shr[svmb_pkg::PROD_W-1:svmb_pkg::SAMPLE_W-1]) ||
        !(|o_shr[svmb_pkg::PROD_W-1:svmb_pkg::SAMPLE_W-1])) begin
      o_sat = o_shr[svmb_pkg::SAMPLE_W-1:0];
    end else if (o_shr[svmb_pkg::PROD_W-1]) begin
      o_sat = {1'b1, {(svmb_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      o_sat = {1'b0, {(svmb_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  // Output register.
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample <= o_sat;
    end
  end

  // The filter input history shifts by exactly the sample just mixed.
  a_delay_shift: assert property (@(posedge clk) disable iff (rst)
    cmd.y_load |=> (in_delay_one == $past(x_reg)) && (in_delay_two == $past(in_delay_one)))
    else $error("input delay line did not shift correctly");

  // A new output word only appears after the sequencer loads one.
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid rose without a load");

endmodule

`default_nettype wire

// ===== sv/sine_voice_mixer_biquad_core.sv =====
`default_nettype none

// Additive sine synthesizer with a lowpass biquad. A word with op = 0 stores the
// phase step and gain of one voice without stalling the input; it produces no output.
// A word with op = 1 renders one sample: every voice with nonzero step and gain
// adds gain * sine(phase) to the mix and advances its phase, the mix runs
// through a direct-form-I biquad (b2 = b0), is scaled by master_gain and is
// saturated to signed Q1.15. A tick keeps the input stalled after it is
// accepted until its sample is loaded into the output register, including any
// wait for the previous sample to leave that register; one shared multiplier
// serves every voice, each of the five filter taps and the master gain in turn.
// Voice and filter state is all zero after reset. The user must write
// coefficients and master_gain through the register port only while the block
// is idle; the block itself does not enforce this.
module sine_voice_mixer_biquad_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                op,
  input  wire logic [2:0]                          voice,
  input  wire logic [svmb_pkg::PHASE_W-1:0]        phase_step,
  input  wire logic [svmb_pkg::GAIN_W-1:0]         voice_gain,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [svmb_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [svmb_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready
);

  svmb_pkg::cfg_t  cfg;
  svmb_pkg::cmd_t  cmd;
  svmb_pkg::stat_t stat;

  svmb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  svmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .stat     (stat),
    .cmd      (cmd)
  );

  svmb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg        (cfg),
    .voice      (voice),
    .phase_step (phase_step),
    .voice_gain (voice_gain),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample     (sample)
  );

endmodule

`default_nettype wire

// ===== bench/sine_voice_mixer_biquad_core_tb.sv =====
`default_nettype none

module sine_voice_mixer_biquad_core_tb;
  import svmb_pkg::*;

  typedef longint unsigned u64_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Fixed-point shifts and rounding terms of the datapath.
  localparam int    MIX_TO_Q16  = 14;
  localparam int    ACC_TO_Q16  = 20;
  localparam int    GAIN_TO_Q15 = 16;
  localparam longint ACC_ROUND  = 64'sd1 <<< 19;
  localparam longint GAIN_ROUND = 64'sd1 <<< 15;

  localparam u64_t Q30_ONE          = 64'd1 << 30;
  localparam u64_t QUARTER_TURN_Q30 = 64'd1686629713;

  // Cycles to let pass after the last sample before the block counts as idle.
  localparam int DRAIN_CYCLES = 3 * VOICES + 11 + 8;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          op = OP_WRITE;
  logic [2:0]                    voice = '0;
  logic [PHASE_W-1:0]            phase_step = '0;
  logic [GAIN_W-1:0]             voice_gain = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]    sample;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [PADDR_W-1:0]            paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Predicted state of the synthesizer.
  logic [PHASE_W-1:0] voice_phase [VOICES];
  logic [PHASE_W-1:0] voice_step  [VOICES];
  logic [GAIN_W-1:0]  voice_level [VOICES];
  int                 x_hist1;
  int                 x_hist2;
  int                 y_hist1;
  int                 y_hist2;
  cfg_t               filt_cfg;
  int                 sine_lut [QLEN+1];

  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_off_left  = 0;
  int unsigned error_count    = 0;

  sine_voice_mixer_biquad_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .voice      (voice),
    .phase_step (phase_step),
    .voice_gain (voice_gain),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample     (sample),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // Quarter-wave sine values in Q1.15 from an odd Taylor series in Q30.
  initial begin : build_sine_lut
    u64_t ang;
    u64_t ang_sq;
    u64_t series;
    u64_t prod;
    u64_t rounded;
    for (int m = 0; m <= QLEN; m++) begin
      ang = (u64_t'(m) * QUARTER_TURN_Q30) >> QTR_BITS;
      ang_sq = (ang * ang) >> 30;
      series = Q30_ONE;
      for (int k = 0; k < 5; k++) begin
        series = Q30_ONE - ((ang_sq * series) >> 30) / u64_t'((11 - 2 * k) * (10 - 2 * k));
      end
      prod = (ang * series) >> 30;
      rounded = (prod * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (rounded > 64'd32767) begin
        rounded = 64'd32767;
      end
      sine_lut[m] = int'(rounded);
    end
  end

  // The receiver stalls at random, or for a counted hold-off when one is pending.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall = 1'b1;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare every accepted output word with the oldest predicted sample.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected sample %0d with nothing pending", sample);
        end
      end else begin
        if (sample !== expected_samples[0]) begin
          error_count++;
          if (error_count <= 10) begin
            $display("sample mismatch: expected %0d, got %0d", expected_samples[0], sample);
          end
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  function automatic int sat32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -longint'(32'sh7FFF_FFFF) - 1) begin
      return 32'sh8000_0000;
    end
    return int'(v);
  endfunction

  function automatic logic [PHASE_W-1:0] pick_step();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom();
      2: return $urandom_range(1, 1 << 20);
      3: return 32'hFFFF_FFFF;
      4: return 32'h8000_0000;
      default: return $urandom_range(1 << 22, 1 << 27);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(9))
      0: return '0;
      1: return UNITY_Q15;
      2: return GAIN_W'($urandom_range(32769, 65535));
      3: return GAIN_W'($urandom());
      default: return GAIN_W'($urandom_range(1, 32768));
    endcase
  endfunction

  // Offer one word, wait for it to be taken, then update the prediction.
  task automatic send_word(logic op_w, logic [2:0] v, logic [PHASE_W-1:0] st,
                           logic [GAIN_W-1:0] g);
    longint                    mix;
    longint                    x_in;
    longint                    acc;
    longint                    scaled;
    int                        y_filt;
    int                        s_val;
    logic [SINE_ADDR_BITS-1:0] addr;
    logic [QTR_BITS-1:0]       rem;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    op = op_w;
    voice = v;
    phase_step = st;
    voice_gain = g;
    do @(posedge clk); while (in_stall);

    if (op_w == OP_WRITE) begin
      if (int'(v) < VOICES) begin
        voice_step[v] = st;
        voice_level[v] = (g > UNITY_Q15) ? UNITY_Q15 : g;
      end
    end else begin
      // Sum the active voices, then advance their phases.
      mix = 0;
      for (int i = 0; i < VOICES; i++) begin
        if (voice_step[i] != '0 && voice_level[i] != '0) begin
          addr = voice_phase[i][PHASE_W-1 -: SINE_ADDR_BITS];
          rem = addr[QTR_BITS-1:0];
          s_val = addr[QTR_BITS] ? sine_lut[QLEN - int'(rem)] : sine_lut[rem];
          if (addr[SINE_ADDR_BITS-1]) begin
            s_val = -s_val;
          end
          mix += longint'(voice_level[i]) * longint'(s_val);
          voice_phase[i] += voice_step[i];
        end
      end
      x_in = mix >>> MIX_TO_Q16;

      // Direct-form-I biquad with b2 equal to b0.
      acc = longint'($signed(filt_cfg.b0)) * x_in
          + longint'($signed(filt_cfg.b1)) * longint'(x_hist1)
          + longint'($signed(filt_cfg.b0)) * longint'(x_hist2)
          - longint'($signed(filt_cfg.a1)) * longint'(y_hist1)
          - longint'($signed(filt_cfg.a2)) * longint'(y_hist2);
      y_filt = sat32((acc + ACC_ROUND) >>> ACC_TO_Q16);
      x_hist2 = x_hist1;
      x_hist1 = sat32(x_in);
      y_hist2 = y_hist1;
      y_hist1 = y_filt;

      // Master gain, rounding and saturation to Q1.15.
      scaled = (longint'(y_filt) * longint'(filt_cfg.master_gain) + GAIN_ROUND) >>> GAIN_TO_Q15;
      if (scaled > 32767) begin
        scaled = 32767;
      end
      if (scaled < -32768) begin
        scaled = -32768;
      end
      expected_samples.push_back(SAMPLE_W'(scaled));
    end
  endtask

  // Stop offering words and wait until the block has nothing left to do.
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup phase, then an access phase.
  task automatic set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    logic [GAIN_W-1:0] g;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COEF_B0: filt_cfg.b0 = value[COEF_W-1:0];
      REG_COEF_B1: filt_cfg.b1 = value[COEF_W-1:0];
      REG_COEF_A1: filt_cfg.a1 = value[COEF_W-1:0];
      REG_COEF_A2: filt_cfg.a2 = value[COEF_W-1:0];
      REG_MASTER_GAIN: begin
        g = value[GAIN_W-1:0];
        filt_cfg.master_gain = (g > UNITY_Q15) ? UNITY_Q15 : g;
      end
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Load all five registers, with junk in the unused upper bits.
  task automatic set_filter(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                            logic [COEF_W-1:0] a1, logic [COEF_W-1:0] a2,
                            logic [GAIN_W-1:0] mg);
    quiesce();
    set_register(REG_COEF_B0, {8'($urandom()), b0});
    set_register(REG_COEF_B1, {8'($urandom()), b1});
    set_register(REG_COEF_A1, {8'($urandom()), a1});
    set_register(REG_COEF_A2, {8'($urandom()), a2});
    set_register(REG_MASTER_GAIN, {16'($urandom()), mg});
  endtask

  task automatic random_words(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 35) begin
        send_word(OP_WRITE, 3'($urandom_range(7)), pick_step(), pick_gain());
      end else begin
        // Voice fields carry noise on a tick and must be ignored.
        send_word(OP_TICK, 3'($urandom()), $urandom(), 16'($urandom()));
      end
    end
  endtask

  // With every voice silent after reset, a tick renders zero.
  task automatic test_silent_reset();
    send_word(OP_TICK, 3'd0, '0, '0);
  endtask

  // Unity and over-unity gains, muting by step or gain, and a full-scale mix.
  task automatic test_voice_settings();
    send_word(OP_WRITE, 3'd0, 32'h0100_0000, UNITY_Q15);
    send_word(OP_WRITE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_WRITE, 3'd3, 32'h0000_0000, 16'd20000);
    send_word(OP_WRITE, 3'd4, 32'd12345, 16'd0);
    repeat (3) send_word(OP_TICK, 3'd0, '0, '0);
    send_word(OP_WRITE, 3'd1, 32'h0100_0000, UNITY_Q15);
    send_word(OP_WRITE, 3'd2, 32'h0100_0000, 16'h8001);
    send_word(OP_WRITE, 3'd5, 32'h0100_0000, UNITY_Q15);
    send_word(OP_WRITE, 3'd6, 32'h0100_0000, UNITY_Q15);
    send_word(OP_WRITE, 3'd4, 32'h0100_0000, UNITY_Q15);
    repeat (4) send_word(OP_TICK, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // Master gain of zero, a write past the register map, over-unity master gain.
  task automatic test_register_edges();
    quiesce();
    set_register(REG_MASTER_GAIN, 32'd0);
    send_word(OP_TICK, 3'd0, '0, '0);
    quiesce();
    set_register(REG_IDX_W'(NUM_REGS), $urandom());
    set_register(REG_MASTER_GAIN, {16'hA5C3, 16'hFFFF});
    repeat (2) send_word(OP_TICK, 3'd0, '0, '0);
  endtask

  task automatic test_random_steady();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_filter(COEF_B0_RESET, COEF_B1_RESET, COEF_A1_RESET, COEF_A2_RESET, UNITY_Q15);
    random_words(400);
  endtask

  // Hold the output off long enough that ticks back up into the input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiesce();
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (12) send_word(OP_TICK, 3'd0, '0, '0);
  endtask

  task automatic test_random_sender_gaps();
    logic [COEF_W-1:0] b0;
    b0 = COEF_W'($urandom_range(0, 1 << 19));
    send_idle_pct = 73;
    recv_stall_pct = 0;
    set_filter(b0, b0 << 1, COEF_W'($urandom_range(0, 1 << 22)) - COEF_W'(1 << 21),
               COEF_W'($urandom_range(0, 1 << 19)), GAIN_W'($urandom_range(16384, 32768)));
    random_words(400);
  endtask

  // Coefficients at the ends of their range drive the filter into saturation.
  task automatic test_random_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 73;
    set_filter(24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h7F_FFFF, 16'hFFFF);
    random_words(400);
  endtask

  task automatic test_random_mixed_idling();
    send_idle_pct = 37;
    recv_stall_pct = 37;
    set_filter(24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, GAIN_W'($urandom()));
    random_words(200);
    set_filter(COEF_B0_RESET, COEF_B1_RESET, COEF_A1_RESET, COEF_A2_RESET,
               GAIN_W'($urandom_range(1, 32768)));
    random_words(200);
  endtask

  initial begin
    for (int i = 0; i < VOICES; i++) begin
      voice_phase[i] = '0;
      voice_step[i] = '0;
      voice_level[i] = '0;
    end
    x_hist1 = 0;
    x_hist2 = 0;
    y_hist1 = 0;
    y_hist2 = 0;
    filt_cfg.b0 = COEF_B0_RESET;
    filt_cfg.b1 = COEF_B1_RESET;
    filt_cfg.a1 = COEF_A1_RESET;
    filt_cfg.a2 = COEF_A2_RESET;
    filt_cfg.master_gain = UNITY_Q15;

    repeat (9) @(negedge clk);
    rst = 1'b0;
    repeat (2) @(posedge clk);

    test_silent_reset();
    test_voice_settings();
    test_register_edges();
    test_random_steady();
    test_output_backpressure();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_mixed_idling();
    quiesce();

    if (error_count == 0) begin
      $display("sine_voice_mixer_biquad_core_tb passed");
    end else begin
      $display("sine_voice_mixer_biquad_core_tb failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10000000;
    $display("sine_voice_mixer_biquad_core_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
